@@ rtl/core/gstat_pkg.sv @@
package gstat_pkg;

    localparam int GRADE_W   = 7;
    localparam int GRADE_MAX = 100;
    localparam int HIST_N    = GRADE_MAX + 1;
    localparam int HIST_AW   = 7;
    localparam int CNT_W     = 11;
    localparam int MAX_GROUP = 1024;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = 17;
    localparam int SQ_W      = 24;
    localparam int OUT_W     = 15;

    // Division operands: numerator up to (n*sq - sum^2) << 16 fits in 56 bits.
    localparam int NUM_W     = 56;
    localparam int DEN_W     = 21;

    typedef struct packed {
        logic [GRADE_W-1:0] grade;
        logic               last_in_group;
    } gstat_in_t;

    typedef struct packed {
        logic [CNT_W-1:0]   item_total;
        logic [GRADE_W-1:0] min_grade;
        logic [GRADE_W-1:0] max_grade;
        logic [7:0]         median_doubled;
        logic [OUT_W-1:0]   mean_q8;
        logic [OUT_W-1:0]   stddev_q8;
        logic               single_item;
    } gstat_out_t;

    // Totals of one closed group, handed from front to back.
    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq;
        logic [GRADE_W-1:0] mn;
        logic [GRADE_W-1:0] mx;
    } gstat_grp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL1,
        ST_MUL2,
        ST_MDIV,
        ST_SDIV,
        ST_SQRT,
        ST_CLEAR,
        ST_OUT
    } gstat_state_t;

endpackage

@@ rtl/core/gstat_front.sv @@
module gstat_front
    import gstat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  gstat_in_t           in_item,
    // Closed group towards the back part.
    output logic                grp_valid,
    input  logic                grp_ready,
    output gstat_grp_t          grp,
    // Histogram increment port.
    output logic                hist_inc,
    output logic [HIST_AW-1:0]  hist_addr
);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [GRADE_W-1:0] mn_reg, mn_next;
    logic [GRADE_W-1:0] mx_reg, mx_next;
    logic               acc;
    logic               take;
    logic [GRADE_W-1:0] g;

    // A group can only close while the back part is free.
    assign full = !grp_ready;
    assign acc  = push && !full;
    assign g    = (in_item.grade > GRADE_W'(GRADE_MAX)) ? GRADE_W'(GRADE_MAX) : in_item.grade;
    assign take = acc && (cnt_reg < CNT_W'(MAX_GROUP));

    assign hist_inc  = take;
    assign hist_addr = g;

    // Accumulator update; the last grade sends totals and restarts.
    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        mn_next  = mn_reg;
        mx_next  = mx_reg;
        if (take)
        begin
            cnt_next = cnt_reg + 1'b1;
            sum_next = sum_reg + SUM_W'(g);
            sq_next  = sq_reg + SQ_W'(g) * SQ_W'(g);
            if (g < mn_reg) mn_next = g;
            if (g > mx_reg) mx_next = g;
        end
        grp.cnt = cnt_next;
        grp.sum = sum_next;
        grp.sq  = sq_next;
        grp.mn  = mn_next;
        grp.mx  = mx_next;
        if (acc && in_item.last_in_group)
        begin
            cnt_next = '0;
            sum_next = '0;
            sq_next  = '0;
            mn_next  = GRADE_W'(GRADE_MAX);
            mx_next  = '0;
        end
    end

    assign grp_valid = acc && in_item.last_in_group;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            mn_reg  <= GRADE_W'(GRADE_MAX);
            mx_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            mn_reg  <= mn_next;
            mx_reg  <= mx_next;
        end
    end

endmodule

@@ rtl/core/gstat_back.sv @@
module gstat_back
    import gstat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               grp_valid,
    output logic               grp_ready,
    input  gstat_grp_t         grp,
    input  logic               hist_inc,
    input  logic [HIST_AW-1:0] hist_addr,
    output logic               empty,
    input  logic               pop,
    output gstat_out_t         res
);

    // Histogram memory: registered reads for the increments and for the walk.
    logic [CNT_W-1:0]   hist_mem [HIST_N];
    logic [HIST_N-1:0]  hv_reg;

    gstat_state_t       st_reg, st_next;
    gstat_grp_t         g_reg;
    logic [HIST_AW-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [GRADE_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic               lo_ok_reg, lo_ok_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [5:0]         step_reg, step_next;
    logic [OUT_W-1:0]   mean_reg, mean_next;
    logic [OUT_W-1:0]   root_reg, root_next;
    logic [33:0]        srem_reg, srem_next;
    logic [35:0]        prod_a_reg, prod_a_next;
    logic [33:0]        prod_b_reg, prod_b_next;
    logic               busy;
    gstat_out_t         out_reg;
    logic               full_reg;

    // Increment pipeline and walk read registers.
    logic               inc1_reg, inc2_reg;
    logic [HIST_AW-1:0] a1_reg, a2_reg;
    logic [CNT_W-1:0]   rd_reg, wd_reg;
    logic [CNT_W-1:0]   hbase;
    logic [CNT_W-1:0]   hrd_reg;
    logic [HIST_AW-1:0] pidx_reg;
    logic               wv_reg;

    logic [CNT_W-1:0]   hcnt;
    logic [CNT_W-1:0]   rank_lo, rank_hi;
    logic [CNT_W-1:0]   seen_sum;
    logic [NUM_W:0]     rem_sh;
    logic [NUM_W-1:0]   num_sh;
    logic [33:0]        sq_trial;

    // The walk consumes the bin read on the previous cycle.
    assign hcnt     = hrd_reg;
    assign seen_sum = seen_reg + hcnt;
    assign rank_hi  = g_reg.cnt >> 1;
    assign rank_lo  = g_reg.cnt[0] ? rank_hi : rank_hi - 1'b1;
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign num_sh   = num_reg << 1;
    assign sq_trial = {srem_reg[31:0], num_reg[NUM_W-1 -: 2]} - {17'd0, root_reg, 2'b01};
    assign busy     = (st_reg != ST_IDLE);
    assign grp_ready = !busy;

    // A write by the increment just before, to the same bin, is newer than the memory read.
    assign hbase    = (inc2_reg && a2_reg == a1_reg) ? wd_reg : rd_reg;

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (grp_valid) st_next = ST_MUL1;
            ST_MUL1:  st_next = ST_MUL2;
            ST_MUL2:  st_next = ST_WALK;
            ST_WALK:  if (idx_reg == HIST_AW'(HIST_N - 1)) st_next = ST_MDIV;
            ST_MDIV:  if (step_reg == 6'd0) st_next = ST_SDIV;
            ST_SDIV:  if (step_reg == 6'd0) st_next = ST_SQRT;
            ST_SQRT:  if (step_reg == 6'd0) st_next = ST_CLEAR;
            ST_CLEAR: st_next = ST_OUT;
            ST_OUT:   if (!full_reg) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // Datapath per state.
    always_comb
    begin
        idx_next   = idx_reg;
        seen_next  = seen_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        lo_ok_next = lo_ok_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        mean_next  = mean_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        // Median search over the bin that was read last cycle.
        if (wv_reg)
        begin
            if (!lo_ok_reg && seen_sum > rank_lo)
            begin
                lo_next    = pidx_reg;
                lo_ok_next = 1'b1;
            end
            if (seen_reg <= rank_hi && seen_sum > rank_hi)
                hi_next = pidx_reg;
            seen_next = seen_sum;
        end
        unique case (st_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                seen_next  = '0;
                lo_ok_next = 1'b0;
                lo_next    = GRADE_W'(GRADE_MAX);
                hi_next    = GRADE_W'(GRADE_MAX);
            end
            ST_WALK:
            begin
                idx_next  = idx_reg + 1'b1;
            end
            ST_MUL1:
            begin
                prod_a_next = 36'(g_reg.cnt) * 36'(g_reg.sq);
                prod_b_next = 34'(g_reg.sum) * 34'(g_reg.sum);
                den_next    = DEN_W'(g_reg.cnt) * DEN_W'(g_reg.cnt - 1'b1);
            end
            ST_MUL2:
            begin
                // Mean division first: sum << 8 over n.
                num_next  = NUM_W'({g_reg.sum, 8'd0}) << (NUM_W - SUM_W - FRAC_BITS);
                rem_next  = '0;
                quo_next  = '0;
                step_next = 6'(SUM_W + FRAC_BITS - 1);
            end
            ST_MDIV, ST_SDIV:
            begin
                num_next = num_sh;
                if (rem_sh >= {{(NUM_W-CNT_W+1){1'b0}}, g_reg.cnt} && st_reg == ST_MDIV)
                begin
                    rem_next = NUM_W'(rem_sh - (NUM_W+1)'(g_reg.cnt));
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else if (st_reg == ST_SDIV && g_reg.cnt > 1 &&
                         rem_sh >= (NUM_W+1)'(den_reg))
                begin
                    rem_next = NUM_W'(rem_sh - (NUM_W+1)'(den_reg));
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[NUM_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == 6'd0)
                begin
                    if (st_reg == ST_MDIV)
                    begin
                        mean_next = (g_reg.cnt == '0) ? '0 : quo_next[OUT_W-1:0];
                        num_next  = NUM_W'(prod_a_reg - 36'(prod_b_reg)) << 16;
                        rem_next  = '0;
                        quo_next  = '0;
                        step_next = 6'(NUM_W - 1);
                    end
                    else
                    begin
                        // Quotient < 2^30 always; root it two bits at a time.
                        num_next  = NUM_W'(quo_next[29:0]) << (NUM_W - 30);
                        srem_next = '0;
                        root_next = '0;
                        step_next = 6'd14;
                    end
                end
            end
            ST_SQRT:
            begin
                num_next = num_reg << 2;
                if (!sq_trial[33])
                begin
                    srem_next = sq_trial;
                    root_next = {root_reg[OUT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = {srem_reg[31:0], num_reg[NUM_W-1 -: 2]};
                    root_next = {root_reg[OUT_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Histogram: read the bin on acceptance, write it back incremented next cycle.
    always_ff @(posedge clk)
    begin
        if (hist_inc)
            rd_reg <= hv_reg[hist_addr] ? hist_mem[hist_addr] : '0;
        if (inc1_reg)
        begin
            hist_mem[a1_reg] <= hbase + 1'b1;
            wd_reg           <= hbase + 1'b1;
        end
        if (st_reg == ST_WALK)
            hrd_reg <= hv_reg[idx_reg] ? hist_mem[idx_reg] : '0;
        a1_reg   <= hist_addr;
        a2_reg   <= a1_reg;
        pidx_reg <= idx_reg;
    end

    // Valid bits are cleared after the walk; pipeline flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg   <= '0;
            inc1_reg <= 1'b0;
            inc2_reg <= 1'b0;
            wv_reg   <= 1'b0;
        end
        else
        begin
            inc1_reg <= hist_inc;
            inc2_reg <= inc1_reg;
            wv_reg   <= (st_reg == ST_WALK);
            if (st_reg == ST_CLEAR)
                hv_reg <= '0;
            else if (inc1_reg)
                hv_reg[a1_reg] <= 1'b1;
        end
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            full_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && !full_reg)
                full_reg <= 1'b1;
            else if (pop && full_reg)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && grp_valid)
            g_reg <= grp;
        idx_reg    <= idx_next;
        seen_reg   <= seen_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lo_ok_reg  <= lo_ok_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        mean_reg   <= mean_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        if (st_reg == ST_OUT && !full_reg)
        begin
            out_reg.item_total     <= g_reg.cnt;
            out_reg.min_grade      <= g_reg.mn;
            out_reg.max_grade      <= g_reg.mx;
            out_reg.median_doubled <= (g_reg.cnt == '0) ? 8'd0 : 8'(lo_reg) + 8'(hi_reg);
            out_reg.mean_q8        <= mean_reg;
            out_reg.stddev_q8      <= (g_reg.cnt > 1) ? root_reg : '0;
            out_reg.single_item    <= (g_reg.cnt == CNT_W'(1));
        end
    end

    assign empty = !full_reg;
    assign res   = out_reg;

endmodule

@@ rtl/core/group_statistics_top.sv @@
// group_statistics_top: count, min, max, doubled median, mean and sample
// standard deviation over groups of grades.
// Input channel: push/full with in_item (grade, last_in_group). Grades are
// taken one per cycle while the back part is idle; grades above 100 count as
// 100, and grades past the 1024th of a group are dropped.
// Result channel: empty/pop with out_item. One result per group. After the
// last grade the back part forms its products, walks the 101-entry
// histogram (one bin a cycle), runs a mean divide, a variance divide and a
// square root, clears the histogram and loads the result register, at which
// point empty falls. full stays high while the back part works on a group.
// One result register holds a finished result; if the receiver does not pop,
// the next group is still taken in, the back part holds it once computed, and
// full stays high until the result is popped.
// Reset empties everything; the histogram is cleared by valid bits at once.
module group_statistics_top
    import gstat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  gstat_in_t  in_item,
    output logic       empty,
    input  logic       pop,
    output gstat_out_t out_item
);

    logic               grp_valid;
    logic               grp_ready;
    gstat_grp_t         grp;
    logic               hist_inc;
    logic [HIST_AW-1:0] hist_addr;
    logic               front_full;

    gstat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (front_full),
        .in_item   (in_item),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .hist_inc  (hist_inc),
        .hist_addr (hist_addr)
    );

    gstat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .hist_inc  (hist_inc),
        .hist_addr (hist_addr),
        .empty     (empty),
        .pop       (pop),
        .res       (out_item)
    );

    assign full = front_full;

`ifndef SYNTHESIS
    // A delivered result never reports a deviation for a single grade.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.single_item) |-> (out_item.stddev_q8 == '0))
        else $error("single-grade group with nonzero deviation");

    // A waiting result holds while it is not popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed before pop");

    // Minimum never exceeds maximum in a result.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.item_total != '0) |-> (out_item.min_grade <= out_item.max_grade))
        else $error("min above max");
`endif

endmodule
